// ===== rtl/slsd_pkg.sv =====
// Shared types and constants for the sync/length/sum deframer.
// No dependencies; used by every module in rtl/.
package slsd_pkg;

  localparam int FRAME_CAPACITY_DEF = 80;
  localparam int QUEUE_DEPTH_DEF    = 4;

  localparam logic [7:0] SYNC_BYTE      = 8'hBB;
  localparam logic [7:0] HDR_FIRST      = 8'h41;
  localparam logic [7:0] HDR_SECOND     = 8'hA1;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd5;

  localparam logic [1:0] KIND_TEXT    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_HEADER = 2'd1;
  localparam logic [1:0] ST_BAD_SUM    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW   = 2'd3;

  // header positions within the frame
  localparam logic [6:0] POS_IDLE   = 7'd0;
  localparam logic [6:0] POS_HDR1   = 7'd1;
  localparam logic [6:0] POS_HDR2   = 7'd2;
  localparam logic [6:0] POS_LENGTH = 7'd3;
  localparam logic [6:0] POS_BODY   = 7'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [6:0] payload_index;
    logic [1:0] frame_status;
    logic [7:0] payload_length;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_wr_t;

endpackage

// ===== rtl/slsd_front.sv =====
// Front end: frame tracking and per-word classification.
// Depends on slsd_pkg; writes result_wr_t words into the result queue.
module slsd_front #(
  parameter int FRAME_CAPACITY = slsd_pkg::FRAME_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  output slsd_pkg::result_wr_t wr
);

  logic [6:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] declared_length_r, declared_length_nxt;
  logic       header_good_r, header_good_nxt;

  logic [7:0] sum_plus;
  logic       last_byte;

  assign sum_plus  = running_sum_r + rx_byte;
  // frame total compared unwrapped, so long declared lengths end in overflow
  assign last_byte = ({2'b00, byte_count_r} + 9'd1) ==
                     ({1'b0, declared_length_r} + slsd_pkg::FRAME_OVERHEAD);

  always_comb begin
    byte_count_nxt      = byte_count_r;
    running_sum_nxt     = running_sum_r;
    declared_length_nxt = declared_length_r;
    header_good_nxt     = header_good_r;
    wr                  = '0;

    if (byte_count_r == slsd_pkg::POS_IDLE) begin
      if (rx_byte != slsd_pkg::SYNC_BYTE) begin
        wr.valid           = 1'b1;
        wr.data.kind       = slsd_pkg::KIND_TEXT;
        wr.data.byte_value = rx_byte;
      end else begin
        byte_count_nxt      = slsd_pkg::POS_HDR1;
        running_sum_nxt     = slsd_pkg::SYNC_BYTE;
        declared_length_nxt = '0;
        header_good_nxt     = 1'b1;
      end
    end else if (byte_count_r >= 7'(FRAME_CAPACITY)) begin
      wr.valid               = 1'b1;
      wr.data.kind           = slsd_pkg::KIND_END;
      wr.data.frame_status   = slsd_pkg::ST_OVERFLOW;
      wr.data.payload_length = declared_length_r;
      byte_count_nxt         = '0;
      running_sum_nxt        = '0;
      declared_length_nxt    = '0;
      header_good_nxt        = 1'b1;
    end else if (byte_count_r < slsd_pkg::POS_BODY) begin
      if (byte_count_r == slsd_pkg::POS_HDR1 && rx_byte != slsd_pkg::HDR_FIRST) begin
        header_good_nxt = 1'b0;
      end else if (byte_count_r == slsd_pkg::POS_HDR2 &&
                   rx_byte != slsd_pkg::HDR_SECOND) begin
        header_good_nxt = 1'b0;
      end else if (byte_count_r == slsd_pkg::POS_LENGTH) begin
        declared_length_nxt = rx_byte;
      end
      running_sum_nxt = sum_plus;
      byte_count_nxt  = byte_count_r + 7'd1;
    end else if (last_byte) begin
      wr.valid               = 1'b1;
      wr.data.kind           = slsd_pkg::KIND_END;
      wr.data.payload_length = declared_length_r;
      if (!header_good_r) begin
        wr.data.frame_status = slsd_pkg::ST_BAD_HEADER;
      end else if (running_sum_r != rx_byte) begin
        wr.data.frame_status = slsd_pkg::ST_BAD_SUM;
      end else begin
        wr.data.frame_status = slsd_pkg::ST_OK;
      end
      byte_count_nxt      = '0;
      running_sum_nxt     = '0;
      declared_length_nxt = '0;
      header_good_nxt     = 1'b1;
    end else begin
      wr.valid              = 1'b1;
      wr.data.kind          = slsd_pkg::KIND_PAYLOAD;
      wr.data.byte_value    = rx_byte;
      wr.data.payload_index = byte_count_r - slsd_pkg::POS_BODY;
      running_sum_nxt       = sum_plus;
      byte_count_nxt        = byte_count_r + 7'd1;
    end

    if (!accept) begin
      wr.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r      <= '0;
      running_sum_r     <= '0;
      declared_length_r <= '0;
      header_good_r     <= 1'b1;
    end else if (accept) begin
      byte_count_r      <= byte_count_nxt;
      running_sum_r     <= running_sum_nxt;
      declared_length_r <= declared_length_nxt;
      header_good_r     <= header_good_nxt;
    end
  end

endmodule

// ===== rtl/slsd_back.sv =====
// Back end: short result queue that presents the oldest word to the receiver.
// Depends on slsd_pkg; fed by slsd_front.
module slsd_back #(
  parameter int QUEUE_DEPTH = slsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slsd_pkg::result_wr_t wr,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output slsd_pkg::result_t    head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  slsd_pkg::result_t mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_pop;

  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);
  assign do_pop = pop && !empty;
  assign head   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr.valid && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!wr.valid && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem_r[wr_ptr_r] <= wr.data;
    end
  end

endmodule

// ===== rtl/sync_length_sum_deframer.sv =====
// Sync byte / length / additive checksum deframer, top level.
// Uses slsd_pkg, slsd_front and slsd_back.
//
// Input: one received byte per word on in_rx_byte, taken at a clock edge
// with push high and full low. Idle bytes other than 0xBB come back as text
// words; 0xBB opens a frame (0x41, 0xA1, length, payload, checksum). Payload
// bytes come out as they arrive, the checksum byte gives a frame end word
// with status and declared length, and a frame that outgrows FRAME_CAPACITY
// bytes ends with status overflow.
// Output: while empty is low the oldest result is on the out_ ports; it is
// taken at an edge with pop high. Each input byte gives zero or one result.
// A result word is written at the input edge that takes its byte, and empty
// is low right after that edge. Throughput is one byte per cycle while full
// is low. The QUEUE_DEPTH-entry result queue absorbs receiver stalls; full
// rises only when it holds QUEUE_DEPTH unread results, and nothing is lost.
// Reset (rst_n low, synchronous) empties the queue and returns the front end
// to idle with the sum cleared.
module sync_length_sum_deframer #(
  parameter int FRAME_CAPACITY = slsd_pkg::FRAME_CAPACITY_DEF,
  parameter int QUEUE_DEPTH    = slsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte_value,
  output logic [6:0] out_payload_index,
  output logic [1:0] out_frame_status,
  output logic [7:0] out_payload_length
);

  slsd_pkg::result_wr_t wr;
  slsd_pkg::result_t    head;
  logic                 accept;

  assign accept = push && !full;

  slsd_front #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .rx_byte(in_rx_byte),
    .wr     (wr)
  );

  slsd_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (wr),
    .pop  (pop),
    .full (full),
    .empty(empty),
    .head (head)
  );

  assign out_kind           = head.kind;
  assign out_byte_value     = head.byte_value;
  assign out_payload_index  = head.payload_index;
  assign out_frame_status   = head.frame_status;
  assign out_payload_length = head.payload_length;

endmodule
